// ===== hw/rtl/point_box_distance_bounds_top_defines.svh =====
// Assertion macros shared by the point-to-box distance bounds RTL.
// No dependencies; each macro expects clk and arst_n in the enclosing scope.
`ifndef POINT_BOX_DISTANCE_BOUNDS_TOP_DEFINES_SVH
`define POINT_BOX_DISTANCE_BOUNDS_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PBDB_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PBDB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/pbdb_pkg.sv =====
// Package for the point-to-box distance bounds block: widths, payload and
// square-root chain types. No dependencies.
package pbdb_pkg;

	localparam int COORD_W = 16;          // Q8.8 coordinate width
	localparam int DIFF_W  = COORD_W + 1; // signed difference of two coordinates
	localparam int MAG_W   = COORD_W;     // magnitude of such a difference
	localparam int SQ_W    = 2 * MAG_W;   // squared magnitude
	localparam int SUM_W   = 44;          // Q28.16 running sum
	localparam int ROOT_W  = SUM_W / 2;   // Q14.8 result
	localparam int REM_W   = ROOT_W + 3;  // partial remainder of the root

	typedef struct packed {
		logic signed [COORD_W-1:0] query_coord;
		logic signed [COORD_W-1:0] box_low;
		logic signed [COORD_W-1:0] box_high;
		logic                      last_dim;
	} pbdb_req_t;

	typedef struct packed {
		logic [ROOT_W-1:0] min_dist;
		logic [ROOT_W-1:0] max_dist;
	} pbdb_rsp_t;

	// One square-root lane: radicand bits still to consume, remainder, root so far.
	typedef struct packed {
		logic [SUM_W-1:0]  rad;
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} pbdb_lane_t;

	// What one cell hands to the next each cycle.
	typedef struct packed {
		logic       valid;
		pbdb_lane_t near;
		pbdb_lane_t far;
	} pbdb_stage_t;

endpackage

// ===== hw/rtl/pbdb_acc.sv =====
// Front end: per-dimension gap and farthest-edge distance, squares, and the two
// saturating running sums. Depends on pbdb_pkg and the assertion macro header.
`include "point_box_distance_bounds_top_defines.svh"

module pbdb_acc (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic                 req_fire,
	input  pbdb_pkg::pbdb_req_t  req,
	output pbdb_pkg::pbdb_stage_t stage_s2
);
	import pbdb_pkg::*;

	logic signed [DIFF_W-1:0] q_ext, lo_ext, hi_ext;
	logic signed [DIFF_W-1:0] d_lo, d_hi;
	logic [MAG_W-1:0]         m_lo, m_hi, gap, far;

	logic              valid_s1;
	logic              last_s1;
	logic [SQ_W-1:0]   near_sq_s1, far_sq_s1;

	logic [SUM_W-1:0]  near_sum_q, far_sum_q;
	logic [SUM_W:0]    near_add, far_add;
	logic [SUM_W-1:0]  near_tot, far_tot;

	logic              valid_s2;
	pbdb_lane_t        near_s2, far_s2;

	// Form the outside gap and the larger edge distance
	always_comb begin
		q_ext  = DIFF_W'(req.query_coord);
		lo_ext = DIFF_W'(req.box_low);
		hi_ext = DIFF_W'(req.box_high);
		d_lo   = q_ext - lo_ext;
		d_hi   = q_ext - hi_ext;
		m_lo   = d_lo[DIFF_W-1] ? MAG_W'(-d_lo) : MAG_W'(d_lo);
		m_hi   = d_hi[DIFF_W-1] ? MAG_W'(-d_hi) : MAG_W'(d_hi);
		if (q_ext < lo_ext) begin
			gap = m_lo;
		end else if (q_ext > hi_ext) begin
			gap = m_hi;
		end else begin
			gap = '0;
		end
		far = (m_lo > m_hi) ? m_lo : m_hi;
	end

	// Square both distances into stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= req_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && req_fire) begin
			near_sq_s1 <= gap * gap;
			far_sq_s1  <= far * far;
			last_s1    <= req.last_dim;
		end
	end

	// Saturating add; a carry out clamps at the top of the sum range
	always_comb begin
		near_add = {1'b0, near_sum_q} + (SUM_W+1)'(near_sq_s1);
		far_add  = {1'b0, far_sum_q} + (SUM_W+1)'(far_sq_s1);
		near_tot = near_add[SUM_W] ? '1 : near_add[SUM_W-1:0];
		far_tot  = far_add[SUM_W] ? '1 : far_add[SUM_W-1:0];
	end

	// Accumulate, and on the last dimension hand the totals on and clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			near_sum_q <= '0;
			far_sum_q  <= '0;
			valid_s2   <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1 && last_s1;
			if (valid_s1) begin
				if (last_s1) begin
					near_sum_q <= '0;
					far_sum_q  <= '0;
				end else begin
					near_sum_q <= near_tot;
					far_sum_q  <= far_tot;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1 && last_s1) begin
			near_s2 <= '{rad: near_tot, rem: '0, root: '0};
			far_s2  <= '{rad: far_tot, rem: '0, root: '0};
		end
	end

	assign stage_s2 = '{valid: valid_s2, near: near_s2, far: far_s2};

	`PBDB_ASSERT_NEXT(a_clear_after_last, adv && valid_s1 && last_s1, near_sum_q == '0 && far_sum_q == '0, "sums not cleared after last dimension")
	`PBDB_ASSERT_NEXT(a_hold_on_stall, !adv, $stable(near_sum_q) && $stable(far_sum_q) && $stable(valid_s1), "front end moved while stalled")
	`PBDB_ASSERT_NEXT(a_launch_root, adv && valid_s1 && last_s1, stage_s2.valid, "totals not launched into root chain")

endmodule

// ===== hw/rtl/pbdb_cell.sv =====
// One square-root cell: retires one root bit for each of the two sums and
// hands the partial result to the next cell. Depends on pbdb_pkg.
module pbdb_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	input  pbdb_pkg::pbdb_stage_t prev,
	output pbdb_pkg::pbdb_stage_t next
);
	import pbdb_pkg::*;

	pbdb_lane_t near_step, far_step;
	logic       valid_q;
	pbdb_lane_t near_q, far_q;

	// Bring down two radicand bits, try the next root bit, keep it if it fits
	function automatic pbdb_lane_t root_step(input pbdb_lane_t cur);
		logic [REM_W-1:0] part;
		logic [REM_W-1:0] trial;
		pbdb_lane_t       res;
		part  = {cur.rem[REM_W-3:0], cur.rad[SUM_W-1:SUM_W-2]};
		trial = {1'b0, cur.root, 2'b01};
		res.rad = {cur.rad[SUM_W-3:0], 2'b00};
		if (part >= trial) begin
			res.rem  = part - trial;
			res.root = {cur.root[ROOT_W-2:0], 1'b1};
		end else begin
			res.rem  = part;
			res.root = {cur.root[ROOT_W-2:0], 1'b0};
		end
		return res;
	endfunction

	always_comb begin
		near_step = root_step(prev.near);
		far_step  = root_step(prev.far);
	end

	// Advance the valid mark with the chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= prev.valid;
		end
	end

	// Advance the partial roots only when they carry a request
	always_ff @(posedge clk) begin
		if (adv && prev.valid) begin
			near_q <= near_step;
			far_q  <= far_step;
		end
	end

	assign next = '{valid: valid_q, near: near_q, far: far_q};

endmodule

// ===== hw/rtl/point_box_distance_bounds_top.sv =====
// Point-to-box distance bounds. Each request carries one dimension (query
// coordinate and box edges, signed Q8.8); the block squares the outside gap and
// the farthest-edge distance, sums them with saturation at 2^44-1, and on the
// request marked last_dim returns floor square roots of both sums in Q14.8 as
// min_dist and max_dist, then starts the next vector from zero. One request is
// taken every cycle while the output side keeps up. The squares are registered
// at the edge that takes the last request, then the totals, then each of the 22
// root cells adds one result bit. Back-pressure on rsp stalls the whole chain, so
// req_ready follows rsp_ready while a result is waiting.
// Depends on pbdb_pkg, pbdb_acc, pbdb_cell and the assertion macro header.
`include "point_box_distance_bounds_top_defines.svh"

module point_box_distance_bounds_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  pbdb_pkg::pbdb_req_t req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output pbdb_pkg::pbdb_rsp_t rsp
);
	import pbdb_pkg::*;

	logic        adv;
	logic        req_fire;
	pbdb_stage_t chain [0:ROOT_W];

	// Advance everything unless a finished result is held
	assign adv       = !chain[ROOT_W].valid || rsp_ready;
	assign req_ready = adv;
	assign req_fire  = req_valid && adv;

	pbdb_acc u_acc (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.req_fire (req_fire),
		.req      (req),
		.stage_s2 (chain[0])
	);

	// Row of root cells, most significant bit first
	for (genvar i = 0; i < ROOT_W; i++) begin : g_cell
		pbdb_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.prev   (chain[i]),
			.next   (chain[i+1])
		);
	end

	assign rsp_valid = chain[ROOT_W].valid;
	assign rsp       = '{min_dist: chain[ROOT_W].near.root, max_dist: chain[ROOT_W].far.root};

	`PBDB_ASSERT_NOW(a_min_le_max, rsp_valid, rsp.min_dist <= rsp.max_dist, "min distance above max distance")

endmodule

// ===== tb/tb_point_box_distance_bounds_top.sv =====
// Self-checking bench for point_box_distance_bounds_top: streamed dimensions
// in, min/max point-to-box distances out, predicted per vector and compared.
// Depends on pbdb_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb_point_box_distance_bounds_top;
	import pbdb_pkg::*;

	localparam longint unsigned SUM_LIMIT = (64'd1 << SUM_W) - 64'd1;
	localparam int PHASE_LEN   = 150;
	localparam int DRAIN_WAIT  = 48;
	localparam int RANDOM_REQS = 1350;

	typedef enum logic [1:0] {
		PH_FLOW,
		PH_SRC_IDLE,
		PH_SNK_STALL,
		PH_BOTH
	} idle_phase_e;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_ready;
	pbdb_req_t req = '0;
	logic      rsp_valid;
	logic      rsp_ready = 1'b0;
	pbdb_rsp_t rsp;

	pbdb_req_t       pending_dims[$];
	pbdb_rsp_t       expected_bounds[$];
	longint unsigned near_acc = 0;
	longint unsigned far_acc = 0;
	int              accepted_dims = 0;
	int              errors = 0;

	point_box_distance_bounds_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Floor square root, one result bit at a time from the top
	function automatic longint unsigned floor_root(input longint unsigned v);
		longint unsigned root;
		longint unsigned trial;
		root = 0;
		for (int b = ROOT_W - 1; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (trial * trial <= v)
				root = trial;
		end
		return root;
	endfunction

	// Fold one dimension into the running sums; queue the bounds on the last one
	task automatic accumulate_dim(input pbdb_req_t d);
		logic signed [DIFF_W-1:0] q, lo, hi;
		logic signed [DIFF_W-1:0] dl, dh;
		longint unsigned gap, far, mdl, mdh;
		pbdb_rsp_t bounds;
		q  = $signed(d.query_coord);
		lo = $signed(d.box_low);
		hi = $signed(d.box_high);
		if (q < lo)
			gap = longint'(lo - q);
		else if (q > hi)
			gap = longint'(q - hi);
		else
			gap = 0;
		dl  = q - lo;
		dh  = q - hi;
		mdl = (dl < 0) ? longint'(-dl) : longint'(dl);
		mdh = (dh < 0) ? longint'(-dh) : longint'(dh);
		far = (mdl > mdh) ? mdl : mdh;
		near_acc = near_acc + gap * gap;
		if (near_acc > SUM_LIMIT)
			near_acc = SUM_LIMIT;
		far_acc = far_acc + far * far;
		if (far_acc > SUM_LIMIT)
			far_acc = SUM_LIMIT;
		if (d.last_dim) begin
			bounds.min_dist = ROOT_W'(floor_root(near_acc));
			bounds.max_dist = ROOT_W'(floor_root(far_acc));
			expected_bounds.push_back(bounds);
			near_acc = 0;
			far_acc = 0;
		end
	endtask

	function automatic idle_phase_e current_phase();
		return idle_phase_e'((accepted_dims / PHASE_LEN) % 4);
	endfunction

	function automatic int src_idle_pct(input idle_phase_e ph);
		case (ph)
			PH_SRC_IDLE: return 61;
			PH_BOTH:     return 24;
			default:     return 0;
		endcase
	endfunction

	function automatic int snk_stall_pct(input idle_phase_e ph);
		case (ph)
			PH_SNK_STALL: return 61;
			PH_BOTH:      return 24;
			default:      return 0;
		endcase
	endfunction

	// Driver: hold the request until taken, then predict and offer the next
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req       <= '0;
		end else begin
			if (req_valid && req_ready) begin
				accumulate_dim(req);
				accepted_dims++;
			end
			if (!req_valid || req_ready) begin
				if (pending_dims.size() != 0 &&
				    $urandom_range(99) >= src_idle_pct(current_phase())) begin
					req       <= pending_dims.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each taken result with the oldest expected bounds
	always @(posedge clk or negedge arst_n) begin
		pbdb_rsp_t want;
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (expected_bounds.size() == 0) begin
					$display("%0t: unexpected result min_dist=%0d max_dist=%0d",
						$time, rsp.min_dist, rsp.max_dist);
					errors++;
				end else begin
					want = expected_bounds.pop_front();
					if (rsp.min_dist !== want.min_dist) begin
						$display("%0t: min_dist expected %0d actual %0d",
							$time, want.min_dist, rsp.min_dist);
						errors++;
					end
					if (rsp.max_dist !== want.max_dist) begin
						$display("%0t: max_dist expected %0d actual %0d",
							$time, want.max_dist, rsp.max_dist);
						errors++;
					end
				end
			end
			rsp_ready <= ($urandom_range(99) >= snk_stall_pct(current_phase()));
		end
	end

	task automatic push_dim(input int q, input int lo, input int hi, input bit last);
		pbdb_req_t d;
		d.query_coord = q[COORD_W-1:0];
		d.box_low     = lo[COORD_W-1:0];
		d.box_high    = hi[COORD_W-1:0];
		d.last_dim    = last;
		pending_dims.push_back(d);
	endtask

	function automatic int pick_extreme();
		case ($urandom_range(5))
			0:       return -32768;
			1:       return 32767;
			2:       return 0;
			3:       return -1;
			4:       return 1;
			default: return $urandom_range(65535) - 32768;
		endcase
	endfunction

	// One random dimension: ordered box, query inside, any edges, or extremes
	task automatic push_random_dim(input bit last);
		int a, b, lo, hi, q;
		a = $urandom_range(65535) - 32768;
		b = $urandom_range(65535) - 32768;
		q = $urandom_range(65535) - 32768;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		case ($urandom_range(9))
			0, 1, 2, 3: push_dim(q, lo, hi, last);
			4, 5:       push_dim(lo + $urandom_range(hi - lo), lo, hi, last);
			6, 7:       push_dim(q, a, b, last);
			default:    push_dim(pick_extreme(), pick_extreme(), pick_extreme(), last);
		endcase
	endtask

	initial begin
		int queued, len;

		// Directed: zero, extremes, inside, swapped edges, short vectors
		push_dim(0, 0, 0, 1'b1);
		push_dim(-32768, 32767, 32767, 1'b1);
		push_dim(32767, -32768, -32768, 1'b1);
		push_dim(0, -32768, 32767, 1'b1);
		push_dim(-32768, -32768, 32767, 1'b1);
		push_dim(32767, -32768, 32767, 1'b1);
		push_dim(0, 100, -100, 1'b1);
		push_dim(200, 100, -100, 1'b1);
		push_dim(-200, 100, -100, 1'b1);
		push_dim(32767, 32767, -32768, 1'b1);
		push_dim(-1, 1, -1, 1'b1);
		push_dim(-32768, 32767, 32767, 1'b0);
		push_dim(32767, -32768, -32768, 1'b0);
		push_dim(-32768, 32767, -32768, 1'b1);
		push_dim(256, -256, 0, 1'b0);
		push_dim(-21846, 21845, -21846, 1'b0);
		push_dim(21845, -21846, 21845, 1'b0);
		push_dim(1, 0, 0, 1'b1);
		push_dim(3, 1, 2, 1'b1);

		// Random vectors, mostly short, a few long
		queued = 0;
		while (queued < RANDOM_REQS) begin
			if ($urandom_range(99) < 70)
				len = $urandom_range(1, 4);
			else if ($urandom_range(99) < 90)
				len = $urandom_range(5, 16);
			else
				len = $urandom_range(17, 64);
			for (int i = 0; i < len; i++)
				push_random_dim(i == len - 1);
			queued += len;
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Drain: all requests taken, all results seen, then let the chain settle
		while (pending_dims.size() != 0 || req_valid)
			@(posedge clk);
		while (expected_bounds.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (errors == 0)
			$display("point_box_distance_bounds_top regression: pass");
		else
			$display("point_box_distance_bounds_top regression: fail");
		$finish;
	end

	// Watchdog
	initial begin
		#10_000_000;
		$display("point_box_distance_bounds_top regression: fail");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/pbdb_pkg.sv
hw/rtl/pbdb_acc.sv
hw/rtl/pbdb_cell.sv
hw/rtl/point_box_distance_bounds_top.sv
tb/tb_point_box_distance_bounds_top.sv
